// ===== design/gdfw_pkg.sv =====
`default_nettype none

package gdfw_pkg;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic push;
        logic pop;
        logic finish;
    } path_cmd_t;

    typedef struct packed {
        logic in_range;
        logic cand_any;
        logic depth_one;
        logic out_free;
    } path_status_t;

endpackage

`default_nettype wire

// ===== design/graph_depth_first_walk_unit.sv =====
// Depth-first walk over a directed graph stored as an adjacency bit matrix.
// Input channel (in_valid/in_stall): cmd, vertex, row_bits. A load beat
// (cmd = 0) stores row_bits as the out-edges of vertex. A start
// beat (cmd = 1) walks from vertex and sends one output beat per reached
// vertex in depth-first preorder, lowest-numbered neighbor first; the final
// beat carries last = 1. A beat naming a vertex beyond the graph is taken
// and dropped.
// Output channel (out_valid/out_stall): visited_vertex, last, from a single
// output register.
// Timing: one stack step (push or pop) per cycle, but a push waits while
// the output register is stalled. in_stall is high for the whole walk, so
// the next beat is taken only after the final beat is registered. The first
// output beat is registered at the first push, or at the finish when the
// start vertex has no out-edges.
// A stalled output register holds the walk at its next push or at the end.
// Reset clears the matrix, the visited marks and the stack depth; the
// block is ready in the first cycle after reset.
`default_nettype none

module graph_depth_first_walk_unit #(
    parameter int VERTICES = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        cmd,
    input  wire logic [3:0]  vertex,
    input  wire logic [15:0] row_bits,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       visited_vertex,
    output logic             last
);

    localparam int VCOUNT = (VERTICES < 16) ? VERTICES : 16;

    gdfw_pkg::path_cmd_t    path_cmd;
    gdfw_pkg::path_status_t status;

    gdfw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .status   (status),
        .path_cmd (path_cmd)
    );

    gdfw_path #(
        .VCOUNT (VCOUNT)
    ) u_path (
        .clk            (clk),
        .rst_n          (rst_n),
        .vertex         (vertex),
        .row_bits       (row_bits),
        .path_cmd       (path_cmd),
        .status         (status),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .visited_vertex (visited_vertex),
        .last           (last)
    );

endmodule

`default_nettype wire

// ===== design/gdfw_ctrl.sv =====
`default_nettype none

module gdfw_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  cmd,
    input  wire gdfw_pkg::path_status_t status,
    output gdfw_pkg::path_cmd_t        path_cmd
);

    gdfw_pkg::state_t state_reg;
    gdfw_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdfw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        path_cmd   = '0;
        unique case (state_reg)
            gdfw_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid && status.in_range)
                begin
                    if (cmd == gdfw_pkg::CMD_LOAD)
                    begin
                        path_cmd.load = 1'b1;
                    end
                    else
                    begin
                        path_cmd.start = 1'b1;
                        state_next     = gdfw_pkg::ST_WALK;
                    end
                end
            end
            gdfw_pkg::ST_WALK:
            begin
                if (status.cand_any)
                begin
                    path_cmd.push = status.out_free;
                end
                else
                begin
                    path_cmd.pop = 1'b1;
                    if (status.depth_one)
                    begin
                        state_next = gdfw_pkg::ST_FINISH;
                    end
                end
            end
            gdfw_pkg::ST_FINISH:
            begin
                if (status.out_free)
                begin
                    path_cmd.finish = 1'b1;
                    state_next      = gdfw_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gdfw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/gdfw_path.sv =====
`default_nettype none

module gdfw_path #(
    parameter int VCOUNT = 16
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [3:0]             vertex,
    input  wire logic [15:0]            row_bits,
    input  wire gdfw_pkg::path_cmd_t    path_cmd,
    output gdfw_pkg::path_status_t      status,
    input  wire logic                   out_stall,
    output logic                        out_valid,
    output logic [3:0]                  visited_vertex,
    output logic                        last
);

    localparam int VW = $clog2(VCOUNT);
    localparam int DW = $clog2(VCOUNT + 1);

    logic [VCOUNT-1:0] adj_reg [VCOUNT];
    logic [VW-1:0]     stack_reg [VCOUNT];
    logic [VCOUNT-1:0] visited_reg;
    logic [DW-1:0]     depth_reg;
    logic [VW-1:0]     pend_reg;
    logic              out_valid_reg;
    logic [3:0]        vertex_out_reg;
    logic              last_reg;

    logic [VW-1:0]     vidx;
    logic [DW-1:0]     top_ptr;
    logic [VW-1:0]     top_v;
    logic [VCOUNT-1:0] cand;
    logic [VW-1:0]     nx;

    function automatic logic [VW-1:0] lowest_set(input logic [VCOUNT-1:0] m);
        logic [VW-1:0] r;
        r = '0;
        for (int i = VCOUNT - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = VW'(i);
            end
        end
        return r;
    endfunction

    assign vidx    = vertex[VW-1:0];
    assign top_ptr = depth_reg - DW'(1);
    assign top_v   = stack_reg[top_ptr[VW-1:0]];
    assign cand    = adj_reg[top_v] & ~visited_reg;
    assign nx      = lowest_set(cand);

    assign status.in_range  = ({1'b0, vertex} < 5'(VCOUNT));
    assign status.cand_any  = |cand;
    assign status.depth_one = (depth_reg == DW'(1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VCOUNT; i++)
            begin
                adj_reg[i] <= '0;
            end
        end
        else if (path_cmd.load)
        begin
            adj_reg[vidx] <= row_bits[VCOUNT-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_cmd.start)
        begin
            stack_reg[0] <= vidx;
        end
        else if (path_cmd.push)
        begin
            stack_reg[depth_reg[VW-1:0]] <= nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            depth_reg   <= '0;
        end
        else if (path_cmd.start)
        begin
            visited_reg <= VCOUNT'(1) << vidx;
            depth_reg   <= DW'(1);
        end
        else if (path_cmd.push)
        begin
            visited_reg <= visited_reg | (VCOUNT'(1) << nx);
            depth_reg   <= depth_reg + DW'(1);
        end
        else if (path_cmd.pop)
        begin
            depth_reg <= top_ptr;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_cmd.start)
        begin
            pend_reg <= vidx;
        end
        else if (path_cmd.push)
        begin
            pend_reg <= nx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (path_cmd.push || path_cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path_cmd.push || path_cmd.finish)
        begin
            vertex_out_reg <= 4'(pend_reg);
            last_reg       <= path_cmd.finish;
        end
    end

    assign out_valid      = out_valid_reg;
    assign visited_vertex = vertex_out_reg;
    assign last           = last_reg;

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DW'(VCOUNT))
        else $error("stack depth beyond vertex count");

    a_push_slot: assert property (@(posedge clk) disable iff (!rst_n)
        path_cmd.push |-> (!out_valid_reg || !out_stall))
        else $error("push while output slot is held");

    a_push_marks: assert property (@(posedge clk) disable iff (!rst_n)
        path_cmd.push |=> visited_reg[$past(nx)])
        else $error("pushed vertex not marked visited");

    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        path_cmd.finish |=> (out_valid_reg && last_reg && depth_reg == '0))
        else $error("final beat missing last flag");

endmodule

`default_nettype wire
